>>> hw/rtl/owsm_pkg.sv
// owsm_pkg: constants and widths shared by the omni wheel speed mixer
// no dependencies
`default_nettype none
package owsm_pkg;
    localparam int STAGES = 10;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 18;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_OFFSET = 8'd3;

    typedef struct packed {
        logic [17:0] count_scale;
        logic [15:0] half_base;
    } owsm_cfg_t;
endpackage
`default_nettype wire

>>> hw/rtl/omni_wheel_speed_mixer.sv
// omni_wheel_speed_mixer: three wheel omni drive speed mixer, top level
// depends on owsm_pkg and owsm_wheel_cell
//
// channel   ports              direction
// command   s_valid / s_ready  in: linear_speed, heading, turn_rate
// rates     m_valid / m_ready  out: three wheel rates and clipped
// config    cfg_wr_en          in: cfg_index, cfg_data
//
// one item per cycle, through the three cells' register chains (sine
// polynomial, mixing, split scaling product)
// the whole chain holds while a result waits; reset clears the valid chain
// and loads the register defaults
`default_nettype none
module omni_wheel_speed_mixer #(
    parameter int ANGLE_BITS = 16,
    parameter int RATE_BITS = 20
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [owsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [owsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [15:0]                  s_linear_speed,
    input  wire logic [15:0]                         s_heading,
    input  wire logic signed [15:0]                  s_turn_rate,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [RATE_BITS-1:0]              m_wheel_one_rate,
    output logic signed [RATE_BITS-1:0]              m_wheel_two_rate,
    output logic signed [RATE_BITS-1:0]              m_wheel_three_rate,
    output logic                                     m_clipped
);
    import owsm_pkg::*;

    logic [17:0] count_scale_reg;
    logic [15:0] half_base_reg;
    logic [15:0] second_offset_reg;
    logic [15:0] third_offset_reg;
    logic [STAGES-1:0] valid_reg, valid_next;
    logic en;
    logic [2:0] clip;
    owsm_cfg_t cfg;

    assign en = !(valid_reg[STAGES-1] && !m_ready);
    assign s_ready = en;
    assign m_valid = valid_reg[STAGES-1];
    assign m_clipped = |clip;
    assign cfg.count_scale = count_scale_reg;
    assign cfg.half_base = half_base_reg;
    assign valid_next = {valid_reg[STAGES-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_scale_reg <= 18'd33422;
            half_base_reg <= 16'd4915;
            second_offset_reg <= 16'd10923;
            third_offset_reg <= 16'd21845;
            valid_reg <= '0;
        end else begin
            if (en) begin
                valid_reg <= valid_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_COUNT_SCALE: count_scale_reg <= cfg_data;
                    REG_HALF_BASE: half_base_reg <= cfg_data[15:0];
                    REG_SECOND_OFFSET: second_offset_reg <= cfg_data[15:0];
                    REG_THIRD_OFFSET: third_offset_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    owsm_wheel_cell #(.ANGLE_BITS(ANGLE_BITS), .RATE_BITS(RATE_BITS)) u_cell_one (
        .aclk(aclk), .en(en), .cfg(cfg), .offset(16'd0),
        .linear_speed(s_linear_speed), .heading(s_heading), .turn_rate(s_turn_rate),
        .rate(m_wheel_one_rate), .clip(clip[0])
    );

    owsm_wheel_cell #(.ANGLE_BITS(ANGLE_BITS), .RATE_BITS(RATE_BITS)) u_cell_two (
        .aclk(aclk), .en(en), .cfg(cfg), .offset(second_offset_reg),
        .linear_speed(s_linear_speed), .heading(s_heading), .turn_rate(s_turn_rate),
        .rate(m_wheel_two_rate), .clip(clip[1])
    );

    owsm_wheel_cell #(.ANGLE_BITS(ANGLE_BITS), .RATE_BITS(RATE_BITS)) u_cell_three (
        .aclk(aclk), .en(en), .cfg(cfg), .offset(third_offset_reg),
        .linear_speed(s_linear_speed), .heading(s_heading), .turn_rate(s_turn_rate),
        .rate(m_wheel_three_rate), .clip(clip[2])
    );

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !(m_valid && !m_ready))
        else $error("ready does not follow output stall");
    a_zero_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && count_scale_reg == 18'd0 && $stable(count_scale_reg)
        |-> !m_clipped && m_wheel_one_rate == '0)
        else $error("zero scale gave a nonzero rate");
endmodule
`default_nettype wire

>>> hw/rtl/owsm_wheel_cell.sv
// owsm_wheel_cell: pipelined sine, mixing and count scaling for one wheel
// depends on owsm_pkg
`default_nettype none
module owsm_wheel_cell #(
    parameter int ANGLE_BITS = 16,
    parameter int RATE_BITS = 20
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire owsm_pkg::owsm_cfg_t     cfg,
    input  wire logic [15:0]             offset,
    input  wire logic signed [15:0]      linear_speed,
    input  wire logic [15:0]             heading,
    input  wire logic signed [15:0]      turn_rate,
    output logic signed [RATE_BITS-1:0]  rate,
    output logic                         clip
);
    import owsm_pkg::*;

    localparam int KEEP = (ANGLE_BITS >= 16) ? 16 : ANGLE_BITS;
    localparam logic [15:0] ANGLE_MASK = 16'((17'h1ffff << (16 - KEEP)));
    localparam logic [33:0] HI = 34'((64'd1 << (RATE_BITS - 1)) - 64'd1);

    logic [15:0] angle;
    logic [15:0] am;
    logic [15:0] f;
    logic [33:0] xx;
    logic [29:0] cx;
    logic [32:0] tx;
    logic [33:0] sx;
    logic [17:0] s1;
    logic [53:0] mag;
    logic [33:0] m;

    logic [1:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic [16:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic [16:0] sq2_reg, sq3_reg;
    logic [15:0] t3_reg;
    logic [16:0] t4_reg;
    logic signed [15:0] spd1_reg, spd2_reg, spd3_reg, spd4_reg, spd5_reg;
    logic signed [32:0] p2_1_reg, p2_2_reg, p2_3_reg, p2_4_reg, p2_5_reg, p2_6_reg;
    logic signed [15:0] sine5_reg;
    logic signed [31:0] p1_6_reg;
    logic signed [34:0] v7_reg;
    logic [34:0] pl8_reg;
    logic signed [36:0] ph8_reg;
    logic signed [53:0] prod9_reg;
    logic signed [RATE_BITS-1:0] rate_reg, rate_next;
    logic clip_reg, clip_next;

    always_comb begin
        angle = heading + offset;
        am = angle & ANGLE_MASK;
        f = {am[13:0], 2'b00};
        xx = 34'(x1_reg) * 34'(x1_reg);
        cx = 30'(SIN_C) * 30'(sq2_reg);
        tx = 33'(t3_reg) * 33'(sq3_reg);
        sx = 34'(t4_reg) * 34'(x4_reg);
        s1 = (sx[33:16] + 18'd1) >> 1;
        if (s1 > 18'd32767) begin
            s1 = 18'd32767;
        end
        mag = prod9_reg[53] ? 54'(-prod9_reg) : 54'(prod9_reg);
        m = 34'(mag[53:27]);
        clip_next = 1'b0;
        if (!prod9_reg[53]) begin
            rate_next = RATE_BITS'(m);
            if (m > HI) begin
                rate_next = RATE_BITS'(HI);
                clip_next = 1'b1;
            end
        end else begin
            rate_next = RATE_BITS'(-m);
            if (m > HI + 34'd1) begin
                rate_next = RATE_BITS'(-(HI + 34'd1));
                clip_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg <= am[15:14];
            x1_reg <= am[14] ? 17'h10000 - {1'b0, f} : {1'b0, f};
            spd1_reg <= linear_speed;
            p2_1_reg <= 33'(turn_rate) * 33'(signed'({1'b0, cfg.half_base})) * 33'sd2;

            q2_reg <= q1_reg;
            x2_reg <= x1_reg;
            sq2_reg <= xx[32:16];
            spd2_reg <= spd1_reg;
            p2_2_reg <= p2_1_reg;

            q3_reg <= q2_reg;
            x3_reg <= x2_reg;
            sq3_reg <= sq2_reg;
            t3_reg <= SIN_B - 16'(cx[29:16]);
            spd3_reg <= spd2_reg;
            p2_3_reg <= p2_2_reg;

            q4_reg <= q3_reg;
            x4_reg <= x3_reg;
            t4_reg <= SIN_A - tx[32:16];
            spd4_reg <= spd3_reg;
            p2_4_reg <= p2_3_reg;

            sine5_reg <= q4_reg[1] ? -signed'(16'(s1)) : signed'(16'(s1));
            spd5_reg <= spd4_reg;
            p2_5_reg <= p2_4_reg;

            p1_6_reg <= 32'(spd5_reg) * 32'(sine5_reg);
            p2_6_reg <= p2_5_reg;

            v7_reg <= 35'(p1_6_reg) - 35'(p2_6_reg);

            pl8_reg <= 35'(v7_reg[16:0]) * 35'(cfg.count_scale);
            ph8_reg <= 37'(signed'(v7_reg[34:17])) * 37'(signed'({1'b0, cfg.count_scale}));

            prod9_reg <= (54'(ph8_reg) <<< 17) + signed'(54'(pl8_reg));

            rate_reg <= rate_next;
            clip_reg <= clip_next;
        end
    end

    assign rate = rate_reg;
    assign clip = clip_reg;
endmodule
`default_nettype wire

>>> verif/testbench.sv
// testbench: self-checking bench for omni_wheel_speed_mixer
// drives motion commands, predicts the three wheel rates and clip flag, checks in order
// depends on owsm_pkg and the omni_wheel_speed_mixer rtl
`default_nettype none
module testbench;
    import owsm_pkg::*;

    localparam int RATE_W = 20;
    localparam int LATENCY = STAGES;

    typedef struct packed {
        logic signed [RATE_W-1:0] one;
        logic signed [RATE_W-1:0] two;
        logic signed [RATE_W-1:0] three;
        logic                     clipped;
    } wheel_rates_t;

    typedef struct {
        logic signed [15:0] speed;
        logic [15:0]        heading;
        logic signed [15:0] turn;
        bit                 typed;
        wheel_rates_t       rates;
    } command_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [15:0] s_linear_speed;
    logic [15:0] s_heading;
    logic signed [15:0] s_turn_rate;
    logic m_valid;
    logic m_ready;
    logic signed [RATE_W-1:0] m_wheel_one_rate;
    logic signed [RATE_W-1:0] m_wheel_two_rate;
    logic signed [RATE_W-1:0] m_wheel_three_rate;
    logic m_clipped;

    omni_wheel_speed_mixer u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_linear_speed(s_linear_speed),
        .s_heading(s_heading),
        .s_turn_rate(s_turn_rate),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_wheel_one_rate(m_wheel_one_rate),
        .m_wheel_two_rate(m_wheel_two_rate),
        .m_wheel_three_rate(m_wheel_three_rate),
        .m_clipped(m_clipped)
    );

    // local copy of the registers
    logic [17:0] scale_cfg;
    logic [15:0] half_base_cfg;
    logic [15:0] offset_two_cfg;
    logic [15:0] offset_three_cfg;

    wheel_rates_t pending_rates[$];
    int errors;
    int send_idle;
    int recv_idle;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic signed [16:0] poly_sine(input logic [15:0] angle);
        logic [1:0] quad;
        logic [63:0] x, x2, t, s;
        quad = angle[15:14];
        x = {50'd0, angle[13:0]} << 2;
        if (quad[0])
            x = 64'd65536 - x;
        x2 = (x * x) >> 16;
        t = (64'd4640 * x2) >> 16;
        t = 64'd42048 - t;
        t = (t * x2) >> 16;
        t = 64'd102944 - t;
        s = (t * x) >> 16;
        s = (s + 64'd1) >> 1;
        if (s > 64'd32767)
            s = 64'd32767;
        return quad[1] ? -$signed({1'b0, s[15:0]}) : $signed({1'b0, s[15:0]});
    endfunction

    function automatic logic signed [RATE_W-1:0] wheel_count_rate(
        input logic signed [15:0] speed, input logic signed [15:0] turn,
        input logic [15:0] angle, inout logic clip);
        longint v, prod, mag, r, hi, lo;
        hi = (longint'(1) <<< (RATE_W - 1)) - 1;
        lo = -hi - 1;
        v = longint'(speed) * longint'(poly_sine(angle))
            - 2 * longint'(turn) * longint'({1'b0, half_base_cfg});
        prod = v * longint'({1'b0, scale_cfg});
        mag = (prod < 0) ? -prod : prod;
        mag = mag >>> 27;
        r = (prod < 0) ? -mag : mag;
        if (r > hi) begin
            r = hi;
            clip = 1'b1;
        end
        if (r < lo) begin
            r = lo;
            clip = 1'b1;
        end
        return r[RATE_W-1:0];
    endfunction

    function automatic wheel_rates_t mix_wheels(input logic signed [15:0] speed,
        input logic [15:0] heading, input logic signed [15:0] turn);
        wheel_rates_t w;
        logic clip;
        clip = 1'b0;
        w.one = wheel_count_rate(speed, turn, heading, clip);
        w.two = wheel_count_rate(speed, turn, heading + offset_two_cfg, clip);
        w.three = wheel_count_rate(speed, turn, heading + offset_three_cfg, clip);
        w.clipped = clip;
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [17:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COUNT_SCALE: scale_cfg = val;
            REG_HALF_BASE: half_base_cfg = val[15:0];
            REG_SECOND_OFFSET: offset_two_cfg = val[15:0];
            REG_THIRD_OFFSET: offset_three_cfg = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rates.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic send_command(input logic signed [15:0] speed, input logic [15:0] heading,
        input logic signed [15:0] turn, input bit typed, input wheel_rates_t typed_rates);
        wheel_rates_t w;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_linear_speed <= speed;
        s_heading <= heading;
        s_turn_rate <= turn;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        w = typed ? typed_rates : mix_wheels(speed, heading, turn);
        pending_rates.push_back(w);
    endtask

    // receiver: random stalls, in-order check
    always @(posedge aclk) begin
        wheel_rates_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_rates.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, got %h %h %h %b", $time,
                        m_wheel_one_rate, m_wheel_two_rate, m_wheel_three_rate, m_clipped);
                end else begin
                    want = pending_rates.pop_front();
                    if (want.one !== m_wheel_one_rate) begin
                        errors++;
                        $display("%0t: wheel one expected %0d got %0d", $time,
                            want.one, m_wheel_one_rate);
                    end
                    if (want.two !== m_wheel_two_rate) begin
                        errors++;
                        $display("%0t: wheel two expected %0d got %0d", $time,
                            want.two, m_wheel_two_rate);
                    end
                    if (want.three !== m_wheel_three_rate) begin
                        errors++;
                        $display("%0t: wheel three expected %0d got %0d", $time,
                            want.three, m_wheel_three_rate);
                    end
                    if (want.clipped !== m_clipped) begin
                        errors++;
                        $display("%0t: clipped expected %b got %b", $time,
                            want.clipped, m_clipped);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    command_row_t directed[$];
    wheel_rates_t zero_rates;
    wheel_rates_t any_rates;

    task automatic add_row(input logic signed [15:0] sp, input logic [15:0] hd,
        input logic signed [15:0] tr, input bit typed, input wheel_rates_t w);
        command_row_t r;
        r.speed = sp;
        r.heading = hd;
        r.turn = tr;
        r.typed = typed;
        r.rates = w;
        directed.push_back(r);
    endtask

    task automatic random_commands(input int count);
        int kind;
        logic signed [15:0] sp, tr;
        logic [15:0] hd;
        for (int i = 0; i < count; i++) begin
            kind = int'($urandom_range(3));
            sp = 16'($urandom);
            hd = 16'($urandom);
            tr = 16'($urandom);
            if (kind == 0) begin
                sp = 16'(int'($urandom_range(2047)) - 1024);
                tr = 16'(int'($urandom_range(2047)) - 1024);
            end else if (kind == 1) begin
                sp = $urandom_range(1) ? 16'(32767 - int'($urandom_range(255)))
                                       : 16'(-32768 + int'($urandom_range(255)));
            end
            send_command(sp, hd, tr, 1'b0, any_rates);
        end
    endtask

    initial begin
        errors = 0;
        send_idle = 0;
        recv_idle = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_linear_speed = '0;
        s_heading = '0;
        s_turn_rate = '0;
        scale_cfg = 18'd33422;
        half_base_cfg = 16'd4915;
        offset_two_cfg = 16'd10923;
        offset_three_cfg = 16'd21845;
        zero_rates = '0;
        any_rates = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, defaults after reset
        add_row(16'sd0, 16'd0, 16'sd0, 1'b1, zero_rates);
        add_row(16'sh7fff, 16'd0, 16'sd0, 1'b0, any_rates);
        add_row(16'sh7fff, 16'd16384, 16'sd0, 1'b0, any_rates);
        add_row(16'sh8000, 16'd16384, 16'sd0, 1'b0, any_rates);
        add_row(16'sh7fff, 16'd32768, 16'sd0, 1'b0, any_rates);
        add_row(16'sh7fff, 16'd49152, 16'sd0, 1'b0, any_rates);
        add_row(16'sh7fff, 16'hffff, 16'sd0, 1'b0, any_rates);
        add_row(16'sd0, 16'd0, 16'sh7fff, 1'b0, any_rates);
        add_row(16'sd0, 16'd0, 16'sh8000, 1'b0, any_rates);
        add_row(16'sh8000, 16'hffff, 16'sh7fff, 1'b0, any_rates);
        add_row(16'sh7fff, 16'h5555, 16'sh8000, 1'b0, any_rates);
        add_row(16'sd1, 16'haaaa, 16'shffff, 1'b0, any_rates);
        foreach (directed[i])
            send_command(directed[i].speed, directed[i].heading, directed[i].turn,
                directed[i].typed, directed[i].rates);
        drain();

        // zero scale gives all zero; extreme registers force saturation
        write_reg(REG_COUNT_SCALE, 18'd0);
        send_command(16'sh7fff, 16'd16384, 16'sh8000, 1'b1, zero_rates);
        drain();
        write_reg(REG_COUNT_SCALE, 18'h3ffff);
        write_reg(REG_HALF_BASE, 18'hffff);
        write_reg(REG_SECOND_OFFSET, 18'hffff);
        write_reg(REG_THIRD_OFFSET, 18'h0);
        write_reg(8'hff, 18'h12345);
        send_command(16'sh7fff, 16'd16384, 16'sd0, 1'b1,
            '{20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 1'b1});
        send_command(16'sh8000, 16'd16384, 16'sd0, 1'b1,
            '{20'sh80000, 20'sh80000, 20'sh80000, 1'b1});
        send_command(16'sd0, 16'd0, 16'sh7fff, 1'b0, any_rates);
        drain();

        send_idle = 37;
        recv_idle = 73;
        write_reg(REG_COUNT_SCALE, 18'd1);
        write_reg(REG_HALF_BASE, 18'd0);
        write_reg(REG_SECOND_OFFSET, 18'd1);
        write_reg(REG_THIRD_OFFSET, 18'd32768);
        random_commands(150);
        drain();

        write_reg(REG_COUNT_SCALE, 18'd33422);
        write_reg(REG_HALF_BASE, 18'd4915);
        write_reg(REG_SECOND_OFFSET, 18'd10923);
        write_reg(REG_THIRD_OFFSET, 18'd21845);
        random_commands(150);
        // hold off until everything is back
        s_valid <= 1'b0;
        while (pending_rates.size() != 0)
            @(posedge aclk);

        send_idle = 73;
        recv_idle = 37;
        write_reg(REG_COUNT_SCALE, 18'($urandom));
        write_reg(REG_HALF_BASE, 18'($urandom_range(65535)));
        write_reg(REG_SECOND_OFFSET, 18'($urandom_range(65535)));
        write_reg(REG_THIRD_OFFSET, 18'($urandom_range(65535)));
        random_commands(300);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_COUNT_SCALE, 18'd100000);
        write_reg(REG_HALF_BASE, 18'd60000);
        random_commands(330);
        drain();

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
